// ===== design/lplp_pkg.sv =====
// ----------------------------------------------------------------------------
// lplp_pkg
// shared widths, result codes and defaults of the lexeme position list parser
// ----------------------------------------------------------------------------
package lplp_pkg;

    localparam int CH_W     = 8;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 14;
    localparam int WEIGHT_W = 2;

    localparam int MAX_WORD_BYTES_DEF = 2047;
    localparam int MAX_POSITION_DEF   = 16383;

    localparam logic [KIND_W-1:0] K_BYTE     = 3'd0;
    localparam logic [KIND_W-1:0] K_WORD_END = 3'd1;
    localparam logic [KIND_W-1:0] K_POS      = 3'd2;
    localparam logic [KIND_W-1:0] K_ERROR    = 3'd3;
    localparam logic [KIND_W-1:0] K_END      = 3'd4;

    localparam logic [VALUE_W-1:0] E_SYNTAX    = 14'd0;
    localparam logic [VALUE_W-1:0] E_NO_ESCAPE = 14'd1;
    localparam logic [VALUE_W-1:0] E_ZERO_POS  = 14'd2;
    localparam logic [VALUE_W-1:0] E_TOO_LONG  = 14'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } result_t;

endpackage

// ===== design/lplp_if.sv =====
// ----------------------------------------------------------------------------
// lplp channel interfaces
// valid/ready channels for input bytes, results and the configuration write
// ----------------------------------------------------------------------------
interface lplp_in_if
    import lplp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface lplp_out_if
    import lplp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
    logic                last;

    modport source (output valid, output kind, output value, output weight, output last,
                    input ready);
    modport sink   (input valid, input kind, input value, input weight, input last,
                    output ready);
endinterface

interface lplp_cfg_if;
    logic valid;
    logic ready;
    logic operator_delimited;

    modport source (output valid, output operator_delimited, input ready);
    modport sink   (input valid, input operator_delimited, output ready);
endinterface

// ===== design/lexeme_position_list_parser_top.sv =====
// ----------------------------------------------------------------------------
// lexeme_position_list_parser_top
// parses a text-vector string one byte per request into word bytes, word ends,
// positions with weights, errors and end-of-input results
// ----------------------------------------------------------------------------
// the results of a byte are written into the result queue when the byte is taken and offered from its head
// throughput: one byte per cycle while each byte gives at most one result and result_chan is ready;
//   a byte giving two or three results fills the queue, which the single result port then drains
// a four-entry result queue decouples the sides; bytes are taken while it holds <= 1
// reset: parser state, halt flag, queue pointers and count, and operator_delimited all cleared
// ----------------------------------------------------------------------------
module lexeme_position_list_parser_top
    import lplp_pkg::*;
#(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
    parameter int MAX_POSITION   = MAX_POSITION_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    lplp_in_if.sink           byte_chan,
    lplp_out_if.source        result_chan,
    lplp_cfg_if.sink          cfg
);

    localparam int LEN_W   = $clog2(MAX_WORD_BYTES + 2);
    localparam int POS_CAP = (MAX_POSITION > 9) ? MAX_POSITION : 9;
    localparam int POS_W   = $clog2(POS_CAP + 1);

    localparam logic [LEN_W-1:0]   LEN_MAX = LEN_W'(MAX_WORD_BYTES);
    localparam logic [POS_W+3:0]   POS_MAX = (POS_W + 4)'(MAX_POSITION);

    localparam logic [CH_W-1:0] C_NUL   = 8'h00;
    localparam logic [CH_W-1:0] C_QUOTE = 8'h27;
    localparam logic [CH_W-1:0] C_BSL   = 8'h5C;
    localparam logic [CH_W-1:0] C_COLON = 8'h3A;
    localparam logic [CH_W-1:0] C_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAIN,
        S_ESCAPE,
        S_QUOTED,
        S_QUOTE_SEEN,
        S_POS_START,
        S_POS_TAIL
    } state_t;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_op_char(input logic [CH_W-1:0] c);
        return (c == 8'h21) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h28) || (c == 8'h29);
    endfunction

    // bit 2 set: not a weight letter
    function automatic logic [2:0] weight_of(input logic [CH_W-1:0] c);
        logic [2:0] w;
        w = 3'd4;
        if ((c == 8'h61) || (c == 8'h41) || (c == 8'h2A))
            w = 3'd3;
        else if ((c == 8'h62) || (c == 8'h42))
            w = 3'd2;
        else if ((c == 8'h63) || (c == 8'h43))
            w = 3'd1;
        else if ((c == 8'h64) || (c == 8'h44))
            w = 3'd0;
        return w;
    endfunction

    // parser state
    state_t               state_reg, state_next;
    logic                 esc_reg, esc_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     acc_reg, acc_next;
    logic [WEIGHT_W-1:0]  wt_reg, wt_next;
    logic                 dig_reg, dig_next;
    logic                 halt_reg, halt_next;
    logic                 opd_reg;

    // result queue
    result_t              queue_reg [4];
    logic [1:0]           wr_ptr_reg;
    logic [1:0]           rd_ptr_reg;
    logic [2:0]           count_reg;

    result_t              slot [3];
    logic [1:0]           n_res;

    logic                 accept;
    logic                 pop;

    logic [CH_W-1:0]      c;
    logic                 op;
    logic                 fin;
    logic                 fl;
    logic [VALUE_W-1:0]   fl_code;
    logic                 redo;
    logic                 zero_fail;
    logic [2:0]           w;
    logic [3:0]           d;
    logic [POS_W+3:0]     prod;
    logic [POS_W+13:0]    acc_wide;
    logic [VALUE_W-1:0]   pos_value;

    assign accept = byte_chan.valid && byte_chan.ready;
    assign pop    = result_chan.valid && result_chan.ready;

    assign byte_chan.ready = (count_reg <= 3'd1);
    assign cfg.ready       = 1'b1;

    assign result_chan.valid  = (count_reg != 3'd0);
    assign result_chan.kind   = queue_reg[rd_ptr_reg].kind;
    assign result_chan.value  = queue_reg[rd_ptr_reg].value;
    assign result_chan.weight = queue_reg[rd_ptr_reg].weight;
    assign result_chan.last   = queue_reg[rd_ptr_reg].last;

    always_comb
    begin
        c          = byte_chan.ch;
        op         = opd_reg && is_op_char(c);
        d          = 4'(c - 8'h30);
        w          = weight_of(c);
        prod       = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + (POS_W + 4)'(d);
        acc_wide   = {{VALUE_W{1'b0}}, acc_reg};
        pos_value  = acc_wide[VALUE_W-1:0];

        state_next = state_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        wt_next    = wt_reg;
        dig_next   = dig_reg;
        halt_next  = halt_reg;

        fin        = 1'b0;
        fl         = 1'b0;
        fl_code    = E_SYNTAX;
        redo       = 1'b0;
        zero_fail  = 1'b0;
        n_res      = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot[i] = '0;
        end

        if (halt_reg)
        begin
            if (c == C_NUL)
            begin
                halt_next  = 1'b0;
                state_next = S_IDLE;
                esc_next   = 1'b0;
                len_next   = '0;
                acc_next   = '0;
                wt_next    = '0;
                dig_next   = 1'b0;
                slot[n_res] = '{kind: K_END, value: '0, weight: '0, last: 1'b0};
                n_res = n_res + 2'd1;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    redo = 1'b1;
                end
                S_ESCAPE:
                begin
                    if (c == C_NUL)
                    begin
                        fl      = 1'b1;
                        fl_code = E_NO_ESCAPE;
                    end
                    else
                    begin
                        slot[n_res] = '{kind: K_BYTE, value: VALUE_W'(c), weight: '0,
                                        last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (len_next <= LEN_MAX)
                            len_next = len_next + 1'b1;
                        state_next = esc_reg ? S_QUOTED : S_PLAIN;
                    end
                end
                S_PLAIN:
                begin
                    if (c == C_BSL)
                    begin
                        state_next = S_ESCAPE;
                        esc_next   = 1'b0;
                    end
                    else if (is_blank(c) || (c == C_NUL) || op)
                    begin
                        slot[n_res] = '{kind: K_WORD_END, value: '0, weight: '0, last: 1'b0};
                        n_res = n_res + 2'd1;
                        fin = 1'b1;
                    end
                    else if (c == C_COLON)
                    begin
                        slot[n_res] = '{kind: K_WORD_END, value: '0, weight: '0, last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (opd_reg)
                            fin = 1'b1;
                        else
                            state_next = S_POS_START;
                    end
                    else
                    begin
                        slot[n_res] = '{kind: K_BYTE, value: VALUE_W'(c), weight: '0,
                                        last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (len_next <= LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                end
                S_QUOTED:
                begin
                    if (c == C_QUOTE)
                        state_next = S_QUOTE_SEEN;
                    else if (c == C_BSL)
                    begin
                        state_next = S_ESCAPE;
                        esc_next   = 1'b1;
                    end
                    else if (c == C_NUL)
                        fl = 1'b1;
                    else
                    begin
                        slot[n_res] = '{kind: K_BYTE, value: VALUE_W'(c), weight: '0,
                                        last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (len_next <= LEN_MAX)
                            len_next = len_next + 1'b1;
                    end
                end
                S_QUOTE_SEEN:
                begin
                    if (c == C_QUOTE)
                    begin
                        slot[n_res] = '{kind: K_BYTE, value: VALUE_W'(c), weight: '0,
                                        last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (len_next <= LEN_MAX)
                            len_next = len_next + 1'b1;
                        state_next = S_QUOTED;
                    end
                    else if (len_reg == '0)
                        fl = 1'b1;
                    else
                    begin
                        slot[n_res] = '{kind: K_WORD_END, value: '0, weight: '0, last: 1'b0};
                        n_res = n_res + 2'd1;
                        if (!opd_reg && (c == C_COLON))
                            state_next = S_POS_START;
                        else
                            fin = 1'b1;
                    end
                end
                S_POS_START:
                begin
                    if (!is_digit(c))
                        fl = 1'b1;
                    else
                    begin
                        acc_next   = POS_W'(d);
                        dig_next   = 1'b1;
                        wt_next    = '0;
                        state_next = S_POS_TAIL;
                    end
                end
                S_POS_TAIL:
                begin
                    if (dig_reg && is_digit(c))
                    begin
                        if (prod > POS_MAX)
                            acc_next = POS_W'(MAX_POSITION);
                        else
                            acc_next = prod[POS_W-1:0];
                    end
                    else
                    begin
                        if (dig_reg)
                        begin
                            dig_next = 1'b0;
                            if (acc_reg == '0)
                                zero_fail = 1'b1;
                        end
                        if (zero_fail)
                        begin
                            fl      = 1'b1;
                            fl_code = E_ZERO_POS;
                        end
                        else if (c == C_COMMA)
                        begin
                            slot[n_res] = '{kind: K_POS, value: pos_value, weight: wt_reg,
                                            last: 1'b0};
                            n_res = n_res + 2'd1;
                            state_next = S_POS_START;
                        end
                        else if (!w[2])
                        begin
                            if (wt_reg != '0)
                                fl = 1'b1;
                            else
                                wt_next = w[1:0];
                        end
                        else if (is_blank(c) || (c == C_NUL))
                        begin
                            slot[n_res] = '{kind: K_POS, value: pos_value, weight: wt_reg,
                                            last: 1'b0};
                            n_res = n_res + 2'd1;
                            fin = 1'b1;
                        end
                        else if (!is_digit(c))
                            fl = 1'b1;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                    esc_next   = 1'b0;
                    len_next   = '0;
                    acc_next   = '0;
                    wt_next    = '0;
                    dig_next   = 1'b0;
                    redo       = 1'b1;
                end
            endcase

            // word finished: length check; a word within the limit has the byte taken again from idle
            if (fin)
            begin
                if (len_next > LEN_MAX)
                begin
                    fl      = 1'b1;
                    fl_code = E_TOO_LONG;
                end
                else
                begin
                    state_next = S_IDLE;
                    esc_next   = 1'b0;
                    len_next   = '0;
                    acc_next   = '0;
                    wt_next    = '0;
                    dig_next   = 1'b0;
                    redo       = 1'b1;
                end
            end

            if (fl)
            begin
                slot[n_res] = '{kind: K_ERROR, value: fl_code, weight: '0, last: 1'b0};
                n_res = n_res + 2'd1;
                state_next = S_IDLE;
                esc_next   = 1'b0;
                len_next   = '0;
                acc_next   = '0;
                wt_next    = '0;
                dig_next   = 1'b0;
                if (c == C_NUL)
                begin
                    slot[n_res] = '{kind: K_END, value: '0, weight: '0, last: 1'b0};
                    n_res = n_res + 2'd1;
                end
                else
                    halt_next = 1'b1;
            end

            if (redo)
            begin
                if (c == C_NUL)
                begin
                    slot[n_res] = '{kind: K_END, value: '0, weight: '0, last: 1'b0};
                    n_res = n_res + 2'd1;
                end
                else if (c == C_QUOTE)
                begin
                    state_next = S_QUOTED;
                    len_next   = '0;
                end
                else if (c == C_BSL)
                begin
                    state_next = S_ESCAPE;
                    esc_next   = 1'b0;
                    len_next   = '0;
                end
                else if (op)
                begin
                    slot[n_res] = '{kind: K_ERROR, value: E_SYNTAX, weight: '0, last: 1'b0};
                    n_res = n_res + 2'd1;
                    state_next = S_IDLE;
                    esc_next   = 1'b0;
                    len_next   = '0;
                    acc_next   = '0;
                    wt_next    = '0;
                    dig_next   = 1'b0;
                    halt_next  = 1'b1;
                end
                else if (!is_blank(c))
                begin
                    slot[n_res] = '{kind: K_BYTE, value: VALUE_W'(c), weight: '0, last: 1'b0};
                    n_res = n_res + 2'd1;
                    len_next   = LEN_W'(1);
                    state_next = S_PLAIN;
                end
            end
        end

        if (n_res != 2'd0)
            slot[n_res - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            esc_reg    <= 1'b0;
            len_reg    <= '0;
            acc_reg    <= '0;
            wt_reg     <= '0;
            dig_reg    <= 1'b0;
            halt_reg   <= 1'b0;
            opd_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                opd_reg <= cfg.operator_delimited;
            if (accept)
            begin
                state_reg  <= state_next;
                esc_reg    <= esc_next;
                len_reg    <= len_next;
                acc_reg    <= acc_next;
                wt_reg     <= wt_next;
                dig_reg    <= dig_next;
                halt_reg   <= halt_next;
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < n_res)
                    queue_reg[wr_ptr_reg + 2'(i)] <= slot[i];
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lexeme_position_list_parser_top. A byte driver sends
// text-vector strings in random bursts. A result monitor stalls on a rotating
// pattern and checks each result against a bytewise parser model. It runs
// directed strings for both operator modes and the word length limit, then
// random well-formed strings mixed with noise and broken lists.
// ----------------------------------------------------------------------------
module tb_top;
    import lplp_pkg::*;

    typedef enum logic [2:0] {
        PS_IDLE, PS_PLAIN, PS_ESCAPE, PS_QUOTED, PS_QUOTE_SEEN, PS_POS_START, PS_POS_TAIL
    } parse_state_e;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_BAR    = 8'h7c;

    localparam int NO_WEIGHT = 4;

    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    lplp_in_if  byte_if ();
    lplp_out_if res_if ();
    lplp_cfg_if cfg_if ();

    lexeme_position_list_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_if),
        .result_chan (res_if),
        .cfg         (cfg_if)
    );

    logic [7:0]   byte_queue[$];
    result_t      expected_results[$];
    int           errors = 0;
    string        weight_letters = "AaBbCcDd*";

    // parser model state
    bit           op_delim;
    parse_state_e pstate;
    bit           esc_to_quoted;
    int unsigned  word_len;
    int unsigned  pos_acc;
    logic [1:0]   pend_weight;
    bit           digits_open;
    bit           halted;
    int unsigned  step_results;

    function automatic void push_result(logic [KIND_W-1:0] k, int unsigned v,
                                        logic [WEIGHT_W-1:0] w);
        result_t r;
        if (step_results >= 3)
            return;
        r.kind   = k;
        r.value  = v[VALUE_W-1:0];
        r.weight = w;
        r.last   = 1'b0;
        expected_results.push_back(r);
        step_results++;
    endfunction

    function automatic void clear_parse();
        pstate        = PS_IDLE;
        esc_to_quoted = 1'b0;
        word_len      = 0;
        pos_acc       = 0;
        pend_weight   = 2'd0;
        digits_open   = 1'b0;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function automatic bit is_op(logic [7:0] c);
        return op_delim && (c == CH_BANG || c == CH_AMP || c == CH_BAR ||
                            c == CH_LPAREN || c == CH_RPAREN);
    endfunction

    function automatic void raise_error(logic [VALUE_W-1:0] code, logic [7:0] c);
        push_result(K_ERROR, 32'(code), 2'd0);
        clear_parse();
        if (c == CH_END)
            push_result(K_END, 0, 2'd0);
        else
            halted = 1'b1;
    endfunction

    function automatic void append_byte(logic [7:0] c);
        push_result(K_BYTE, 32'(c), 2'd0);
        if (word_len <= MAX_WORD_BYTES_DEF)
            word_len++;
    endfunction

    // returns 1 when the byte has to be parsed again from idle
    function automatic bit finish_word(logic [7:0] c);
        if (word_len > MAX_WORD_BYTES_DEF)
        begin
            raise_error(E_TOO_LONG, c);
            return 1'b0;
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic int weight_code(logic [7:0] c);
        case (c)
            "a", "A", CH_STAR: return 3;
            "b", "B":          return 2;
            "c", "C":          return 1;
            "d", "D":          return 0;
            default:           return NO_WEIGHT;
        endcase
    endfunction

    function automatic void run_parser(logic [7:0] c);
        bit again;
        int wv;
        again = 1'b1;
        for (int pass = 0; pass < 2 && again; pass++)
        begin
            again = 1'b0;
            case (pstate)
                PS_IDLE:
                begin
                    if (c == CH_END)
                        push_result(K_END, 0, 2'd0);
                    else if (c == CH_QUOTE)
                    begin
                        pstate   = PS_QUOTED;
                        word_len = 0;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        pstate        = PS_ESCAPE;
                        esc_to_quoted = 1'b0;
                        word_len      = 0;
                    end
                    else if (is_op(c))
                        raise_error(E_SYNTAX, c);
                    else if (!is_blank(c))
                    begin
                        word_len = 0;
                        append_byte(c);
                        pstate = PS_PLAIN;
                    end
                end
                PS_ESCAPE:
                begin
                    if (c == CH_END)
                        raise_error(E_NO_ESCAPE, c);
                    else
                    begin
                        append_byte(c);
                        pstate = esc_to_quoted ? PS_QUOTED : PS_PLAIN;
                    end
                end
                PS_PLAIN:
                begin
                    if (c == CH_BSLASH)
                    begin
                        pstate        = PS_ESCAPE;
                        esc_to_quoted = 1'b0;
                    end
                    else if (is_blank(c) || c == CH_END || is_op(c))
                    begin
                        push_result(K_WORD_END, 0, 2'd0);
                        again = finish_word(c);
                    end
                    else if (c == CH_COLON)
                    begin
                        push_result(K_WORD_END, 0, 2'd0);
                        if (op_delim)
                            again = finish_word(c);
                        else
                            pstate = PS_POS_START;
                    end
                    else
                        append_byte(c);
                end
                PS_QUOTED:
                begin
                    if (c == CH_QUOTE)
                        pstate = PS_QUOTE_SEEN;
                    else if (c == CH_BSLASH)
                    begin
                        pstate        = PS_ESCAPE;
                        esc_to_quoted = 1'b1;
                    end
                    else if (c == CH_END)
                        raise_error(E_SYNTAX, c);
                    else
                        append_byte(c);
                end
                PS_QUOTE_SEEN:
                begin
                    if (c == CH_QUOTE)
                    begin
                        append_byte(c);
                        pstate = PS_QUOTED;
                    end
                    else if (word_len == 0)
                        raise_error(E_SYNTAX, c);
                    else
                    begin
                        push_result(K_WORD_END, 0, 2'd0);
                        if (!op_delim && c == CH_COLON)
                            pstate = PS_POS_START;
                        else
                            again = finish_word(c);
                    end
                end
                PS_POS_START:
                begin
                    if (!is_digit(c))
                        raise_error(E_SYNTAX, c);
                    else
                    begin
                        pos_acc     = 32'(c - CH_DIGIT0);
                        digits_open = 1'b1;
                        pend_weight = 2'd0;
                        pstate      = PS_POS_TAIL;
                    end
                end
                PS_POS_TAIL:
                begin
                    if (digits_open && is_digit(c))
                    begin
                        pos_acc = pos_acc * 10 + 32'(c - CH_DIGIT0);
                        if (pos_acc > MAX_POSITION_DEF)
                            pos_acc = MAX_POSITION_DEF;
                    end
                    else if (digits_open && pos_acc == 0)
                        raise_error(E_ZERO_POS, c);
                    else
                    begin
                        digits_open = 1'b0;
                        wv = weight_code(c);
                        if (c == CH_COMMA)
                        begin
                            push_result(K_POS, pos_acc, pend_weight);
                            pstate = PS_POS_START;
                        end
                        else if (wv != NO_WEIGHT)
                        begin
                            if (pend_weight != 2'd0)
                                raise_error(E_SYNTAX, c);
                            else
                                pend_weight = wv[1:0];
                        end
                        else if (is_blank(c) || c == CH_END)
                        begin
                            push_result(K_POS, pos_acc, pend_weight);
                            again = finish_word(c);
                        end
                        else if (!is_digit(c))
                            raise_error(E_SYNTAX, c);
                    end
                end
                default:
                begin
                    clear_parse();
                    again = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        result_t r;
        step_results = 0;
        if (halted)
        begin
            if (c == CH_END)
            begin
                halted = 1'b0;
                clear_parse();
                push_result(K_END, 0, 2'd0);
            end
        end
        else
            run_parser(c);
        if (step_results > 0)
        begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
            report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                      got.kind, got.value));
        else
        begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.value != want.value)
                report_mismatch($sformatf("value %0d, expected %0d (kind %0d)",
                                          got.value, want.value, want.kind));
            if (got.weight != want.weight)
                report_mismatch($sformatf("weight %0d, expected %0d", got.weight,
                                          want.weight));
            if (got.last != want.last)
                report_mismatch($sformatf("last %0d, expected %0d (kind %0d)",
                                          got.last, want.last, want.kind));
        end
    endtask

    // byte driver: bursts of requests with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (byte_if.valid && byte_if.ready)
            predict_byte(byte_if.ch);
        if (!rst_n)
            byte_if.valid <= 1'b0;
        else if (!byte_if.valid || byte_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                byte_if.valid <= 1'b0;
            end
            else if (byte_queue.size() > 0)
            begin
                byte_if.ch    <= byte_queue.pop_front();
                byte_if.valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                byte_if.valid <= 1'b0;
        end
    end

    // result monitor: ready pattern rotates between free flow and stalls
    int unsigned stall_cnt = 0;

    always @(posedge clk)
    begin
        if (res_if.valid && res_if.ready)
            check_result('{kind: res_if.kind, value: res_if.value,
                           weight: res_if.weight, last: res_if.last});
        stall_cnt++;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            case ((stall_cnt / 101) % 4)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= (stall_cnt % 3) != 0;
                2:       res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= (stall_cnt % 13) < 3;
            endcase
    end

    function automatic void push_byte(logic [7:0] b);
        byte_queue.push_back(b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 4))
            0:       return CH_BANG;
            1:       return CH_AMP;
            2:       return CH_BAR;
            3:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    function automatic logic [7:0] rand_word_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 255));
        while (b == CH_COLON || b == CH_BSLASH || b == CH_QUOTE || b == CH_BANG ||
               b == CH_AMP || b == CH_BAR || b == CH_LPAREN || b == CH_RPAREN);
        return b;
    endfunction

    function automatic logic [7:0] rand_quoted_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic void gen_word();
        int unsigned n;
        int unsigned pick;
        n    = $urandom_range(1, 6);
        pick = $urandom_range(0, 19);
        if (pick < 5)
        begin
            push_byte(CH_QUOTE);
            for (int i = 0; i < n; i++)
                case ($urandom_range(0, 7))
                    0:       push_text("''");
                    1:
                    begin
                        push_byte(CH_BSLASH);
                        push_byte(8'($urandom_range(1, 255)));
                    end
                    default: push_byte(rand_quoted_byte());
                endcase
            push_byte(CH_QUOTE);
        end
        else
        begin
            if (pick < 8)
            begin
                push_byte(CH_BSLASH);
                push_byte(8'($urandom_range(1, 255)));
            end
            else
                push_byte(rand_word_byte());
            for (int i = 1; i < n; i++)
                if ($urandom_range(0, 7) == 0)
                begin
                    push_byte(CH_BSLASH);
                    push_byte(8'($urandom_range(1, 255)));
                end
                else
                    push_byte(rand_word_byte());
        end
    endfunction

    function automatic void gen_number();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            push_text("0");
        else if (pick == 1)
            push_text("000");
        else if (pick < 4)
            push_text($sformatf("0%0d", $urandom_range(1, 99)));
        else if (pick < 6)
            push_text($sformatf("%0d", $urandom_range(10000, 999999)));
        else
            push_text($sformatf("%0d", $urandom_range(1, 999)));
    endfunction

    function automatic void gen_pos_list();
        int unsigned n;
        n = $urandom_range(1, 3);
        push_byte(CH_COLON);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                push_byte(CH_COMMA);
            gen_number();
            if ($urandom_range(0, 2) == 0)
            begin
                push_byte(weight_letters[$urandom_range(0, 8)]);
                if ($urandom_range(0, 7) == 0)
                    push_byte(8'(CH_DIGIT0 + $urandom_range(0, 9)));
                if ($urandom_range(0, 11) == 0)
                    push_byte(weight_letters[$urandom_range(0, 8)]);
            end
        end
    endfunction

    function automatic void gen_string();
        int unsigned nw;
        nw = $urandom_range(1, 4);
        for (int i = 0; i < nw; i++)
        begin
            if (i > 0)
            begin
                push_byte(rand_blank());
                if ($urandom_range(0, 3) == 0)
                    push_byte(rand_blank());
                if ($urandom_range(0, 9) == 0)
                    push_byte(rand_op());
            end
            gen_word();
            if ($urandom_range(0, op_delim ? 9 : 2) == 0)
                gen_pos_list();
            if ($urandom_range(0, 11) == 0)
                push_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0)
            push_byte(rand_blank());
        push_byte(CH_END);
    endfunction

    function automatic void gen_random(int unsigned count);
        int unsigned target;
        target = byte_queue.size() + count;
        while (byte_queue.size() < target)
            gen_string();
    endfunction

    task automatic wait_drained();
        while (byte_queue.size() != 0 || byte_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(bit mode);
        @(posedge clk);
        cfg_if.valid              <= 1'b1;
        cfg_if.operator_delimited <= mode;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        op_delim = mode;
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        byte_if.valid             = 1'b0;
        byte_if.ch                = '0;
        res_if.ready              = 1'b0;
        cfg_if.valid              = 1'b0;
        cfg_if.operator_delimited = 1'b0;
        op_delim                  = 1'b0;
        halted                    = 1'b0;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_mode(1'b0);
        // blanks, byte extremes, all weights
        push_text("ab");
        push_byte(CH_TAB);
        push_byte(8'hff);
        push_byte(CH_LF);
        push_byte(8'h80);
        push_byte(CH_VT);
        push_byte(8'h01);
        push_byte(CH_FF);
        push_byte(8'h7f);
        push_byte(CH_CR);
        push_text("!a&");
        push_byte(CH_END);
        push_text("w:1A,2b,3C,4d,5*,6");
        push_byte(CH_END);
        // capping, leading zeros, digits after weight, weight after D
        push_text("x:99999,007,5A77,3DA");
        push_byte(CH_END);
        push_text("y:000 z");
        push_byte(CH_END);
        push_text("y:1AB");
        push_byte(CH_END);
        push_text("q:x");
        push_byte(CH_END);
        push_text("p:4x");
        push_byte(CH_END);
        push_text("a:");
        push_byte(CH_END);
        push_text("a:3,");
        push_byte(CH_END);
        push_text("'it''s' 'a\\'b':2");
        push_byte(CH_END);
        push_text("''");
        push_byte(CH_END);
        push_text("'abc");
        push_byte(CH_END);
        push_text("a\\ b\\");
        push_byte(CH_END);
        push_byte(CH_END);
        wait_drained();

        // word length limit: longest legal word, then one byte over
        for (int i = 0; i < MAX_WORD_BYTES_DEF; i++)
            push_byte("x");
        push_byte(CH_SPACE);
        push_byte(CH_END);
        for (int i = 0; i <= MAX_WORD_BYTES_DEF; i++)
            push_byte("y");
        push_text(":5 k");
        push_byte(CH_END);
        wait_drained();

        write_mode(1'b1);
        push_text("a&b");
        push_byte(CH_END);
        push_text("(x");
        push_byte(CH_END);
        push_text("x)");
        push_byte(CH_END);
        push_text("k!");
        push_byte(CH_END);
        push_text("m|");
        push_byte(CH_END);
        push_text("a:b 'q':1");
        push_byte(CH_END);
        push_text("'r'&");
        push_byte(CH_END);
        wait_drained();

        gen_random(40);
        wait_drained();
        gen_random(40);
        wait_drained();

        write_mode(1'b0);
        gen_random(50);
        wait_drained();
        gen_random(50);
        wait_drained();

        write_mode(1'b1);
        gen_random(25);
        wait_drained();

        if (errors == 0)
            $display("** lexeme_position_list_parser_top: PASSED **");
        else
            $display("** lexeme_position_list_parser_top: FAILED **");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("** lexeme_position_list_parser_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lplp_pkg.sv
design/lplp_if.sv
design/lexeme_position_list_parser_top.sv
verif/tb_top.sv
